@@ sv/qsed_pkg.sv @@
// Package: item types, mode and status codes, character helpers for the string decoder.
`default_nettype none
package qsed_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // one to two results caused by one input word
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } pair_t;

  typedef enum logic [2:0] {
    ModeQuote = 3'd0,
    ModeStr   = 3'd1,
    ModeBsl   = 3'd2,
    ModeHex   = 3'd3,
    ModeOct   = 3'd4,
    ModeAfter = 3'd5,
    ModeErr   = 3'd6
  } mode_e;

  localparam logic [2:0] StBusy      = 3'd0;
  localparam logic [2:0] StDone      = 3'd1;
  localparam logic [2:0] StNoQuote   = 3'd2;
  localparam logic [2:0] StUnterm    = 3'd3;
  localparam logic [2:0] StNoHex     = 3'd4;
  localparam logic [2:0] StMalformed = 3'd5;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowV  = 8'h76;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBs    = 8'h08;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      return {1'b1, t[3:0]};
    end else if (c >= ChLowA && c <= ChLowF) begin
      t = c - ChLowA + 8'd10;
      return {1'b1, t[3:0]};
    end else if (c >= ChUpA && c <= ChUpF) begin
      t = c - ChUpA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
           (c == ChFf) || (c == ChCr);
  endfunction

endpackage
`default_nettype wire

@@ sv/qsed_front.sv @@
// Front part: config register, decode state machine, builds result pairs.
`default_nettype none
module qsed_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire qsed_pkg::in_item_t item_i,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_data_i,
  output qsed_pkg::pair_t       pair_o
);
  import qsed_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic [1:0] dig_q, dig_d;
  logic [2:0] err_q, err_d;
  logic       append_nul_q;

  function automatic mode_e str_next(input logic [7:0] c);
    if (c == ChQuote) return ModeAfter;
    if (c == ChBsl) return ModeBsl;
    return ModeStr;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [4:0] hx;
    logic [7:0] nv;
    logic [1:0] nd;
    out_item_t  r0;
    out_item_t  r1;
    logic       two;
    c       = item_i.ch;
    hx      = hex_digit(c);
    nv      = 8'd0;
    nd      = dig_q + 2'd1;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;
    mode_d  = mode_q;
    val_d   = val_q;
    dig_d   = dig_q;
    err_d   = err_q;
    if (item_i.end_of_text) begin
      case (mode_q)
        ModeQuote: r0.status = StNoQuote;
        ModeStr:   r0.status = StMalformed;
        ModeBsl:   r0.status = StUnterm;
        ModeHex: begin
          if (dig_q == 2'd0) begin
            r0.status = StNoHex;
          end else begin
            r0.out_byte   = val_q;
            r0.byte_valid = 1'b1;
            r1.status     = StMalformed;
            two           = 1'b1;
          end
        end
        ModeOct: begin
          r0.out_byte   = val_q;
          r0.byte_valid = 1'b1;
          r1.status     = StMalformed;
          two           = 1'b1;
        end
        ModeAfter: begin
          r0.byte_valid = append_nul_q;
          r0.status     = StDone;
        end
        default: begin
          r0.status = (err_q >= StNoQuote && err_q <= StMalformed) ? err_q : StMalformed;
        end
      endcase
      mode_d = ModeQuote;
      val_d  = 8'd0;
      dig_d  = 2'd0;
      err_d  = 3'd0;
    end else begin
      case (mode_q)
        ModeQuote: begin
          if (c == ChQuote) begin
            mode_d = ModeStr;
          end else begin
            mode_d = ModeErr;
            err_d  = StNoQuote;
          end
        end
        ModeStr: begin
          mode_d = str_next(c);
          if (str_next(c) == ModeStr) begin
            r0.out_byte   = c;
            r0.byte_valid = 1'b1;
          end
        end
        ModeBsl: begin
          mode_d        = ModeStr;
          r0.byte_valid = 1'b1;
          case (c)
            ChLowA:  r0.out_byte = ChBel;
            ChLowB:  r0.out_byte = ChBs;
            ChLowF:  r0.out_byte = ChFf;
            ChLowN:  r0.out_byte = ChLf;
            ChLowR:  r0.out_byte = ChCr;
            ChLowT:  r0.out_byte = ChTab;
            ChLowV:  r0.out_byte = ChVt;
            ChLowX: begin
              r0.byte_valid = 1'b0;
              mode_d        = ModeHex;
              val_d         = 8'd0;
              dig_d         = 2'd0;
            end
            default: begin
              if (is_oct(c)) begin
                r0.byte_valid = 1'b0;
                mode_d        = ModeOct;
                val_d         = {5'd0, c[2:0]};
                dig_d         = 2'd1;
              end else begin
                r0.out_byte = c;
              end
            end
          endcase
        end
        ModeHex: begin
          if (hx[4]) begin
            nv = {val_q[3:0], hx[3:0]};
            if (nd >= 2'd2) begin
              r0.out_byte   = nv;
              r0.byte_valid = 1'b1;
              mode_d        = ModeStr;
            end
            val_d = nv;
            dig_d = nd;
          end else if (dig_q == 2'd0) begin
            mode_d = ModeErr;
            err_d  = StNoHex;
          end else begin
            r0.out_byte   = val_q;
            r0.byte_valid = 1'b1;
            mode_d        = str_next(c);
            if (str_next(c) == ModeStr) begin
              r1.out_byte   = c;
              r1.byte_valid = 1'b1;
              two           = 1'b1;
            end
          end
        end
        ModeOct: begin
          if (is_oct(c) && dig_q < 2'd3) begin
            nv = {val_q[4:0], c[2:0]};
            if (nd == 2'd3) begin
              r0.out_byte   = nv;
              r0.byte_valid = 1'b1;
              mode_d        = ModeStr;
            end
            val_d = nv;
            dig_d = nd;
          end else begin
            r0.out_byte   = val_q;
            r0.byte_valid = 1'b1;
            mode_d        = str_next(c);
            if (str_next(c) == ModeStr) begin
              r1.out_byte   = c;
              r1.byte_valid = 1'b1;
              two           = 1'b1;
            end
          end
        end
        ModeAfter: begin
          if (!is_ws(c)) begin
            mode_d = ModeErr;
            err_d  = StMalformed;
          end
        end
        default: mode_d = ModeErr;
      endcase
    end
    r0.last     = ~two;
    r1.last     = 1'b1;
    pair_o.two  = two;
    pair_o.r0   = r0;
    pair_o.r1   = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeQuote;
      val_q        <= 8'd0;
      dig_q        <= 2'd0;
      err_q        <= 3'd0;
      append_nul_q <= 1'b1;
    end else begin
      if (accept_i) begin
        mode_q <= mode_d;
        val_q  <= val_d;
        dig_q  <= dig_d;
        err_q  <= err_d;
      end
      if (cfg_valid_i) begin
        append_nul_q <= cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/qsed_fifo.sv @@
// Short queue of result pairs between the front and back parts.
`default_nettype none
module qsed_fifo #(
  parameter int unsigned Depth = qsed_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire qsed_pkg::pair_t wr_data_i,
  output logic                 full_o,
  input  wire logic            rd_i,
  output qsed_pkg::pair_t      rd_data_o,
  output logic                 empty_o
);
  import qsed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pair_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/qsed_back.sv @@
// Back part: output register, hands out one or two results per pair.
`default_nettype none
module qsed_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire qsed_pkg::pair_t q_data_i,
  output logic                 q_rd_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output qsed_pkg::out_item_t  result_o
);
  import qsed_pkg::*;

  pair_t pair_q;
  logic  valid_q, valid_d;
  logic  sel_q, sel_d;
  logic  fire, done, load;

  assign fire     = pop_i & valid_q;
  assign done     = fire & (~pair_q.two | sel_q);
  assign load     = ~q_empty_i & (~valid_q | done);
  assign q_rd_o   = load;
  assign empty_o  = ~valid_q;
  assign result_o = sel_q ? pair_q.r1 : pair_q.r0;

  always_comb begin
    valid_d = load | (valid_q & ~done);
    sel_d   = sel_q;
    if (load) begin
      sel_d = 1'b0;
    end else if (fire && !done) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/quoted_string_escape_decoder.sv @@
// Top level: quoted string escape decoder, front decode, pair queue, output stage.
// A result passes the pair queue, then the output register, on its way to the output.
// Throughput: one input word per cycle; a word with two results holds the output two pops.
// The front stalls only when the pair queue is full.
// Reset: decoder back to expecting the opening quote, append_nul set to 1, queues empty.
`default_nettype none
module quoted_string_escape_decoder #(
  parameter int unsigned Depth = qsed_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire qsed_pkg::in_item_t  item_i,
  output logic                     empty,
  input  wire logic                pop,
  output qsed_pkg::out_item_t      result_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i
);
  import qsed_pkg::*;

  pair_t front_pair;
  pair_t q_data;
  logic  q_full, q_empty, q_rd, accept;

  assign full        = q_full;
  assign accept      = push & ~q_full;
  assign cfg_ready_o = 1'b1;

  qsed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .pair_o      (front_pair)
  );

  qsed_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_pair),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  qsed_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/qsed_checker.sv @@
// Checker: watches the decoder's channels, predicts every result word and compares in order.
module qsed_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  qsed_pkg::in_item_t  item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  qsed_pkg::out_item_t result_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import qsed_pkg::*;

  mode_e      cur_mode;
  logic [7:0] esc_val;
  logic [1:0] esc_cnt;
  logic [2:0] err_st;
  logic       nul_en;
  out_item_t  step_res[2];
  int         step_n;
  out_item_t  decoded_q[$];
  int         mismatches = 0;
  int         pending = 0;
  int         checked = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign checked_o    = checked;

  task automatic emit(input logic [7:0] b, input logic v, input logic [2:0] st);
    if (step_n < 2) begin
      step_res[step_n] = '{out_byte: v ? b : 8'h00, byte_valid: v, status: st, last: 1'b0};
      step_n++;
    end
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == ChQuote) cur_mode = ModeAfter;
    else if (c == ChBsl) cur_mode = ModeBsl;
    else emit(c, 1'b1, StBusy);
  endtask

  task automatic predict_word(input in_item_t w);
    logic [7:0] c;
    int         h;
    step_n = 0;
    c = w.ch;
    if (w.end_of_text) begin
      case (cur_mode)
        ModeQuote: emit(8'h00, 1'b0, StNoQuote);
        ModeStr:   emit(8'h00, 1'b0, StMalformed);
        ModeBsl:   emit(8'h00, 1'b0, StUnterm);
        ModeHex: begin
          if (esc_cnt == 2'd0) begin
            emit(8'h00, 1'b0, StNoHex);
          end else begin
            emit(esc_val, 1'b1, StBusy);
            emit(8'h00, 1'b0, StMalformed);
          end
        end
        ModeOct: begin
          emit(esc_val, 1'b1, StBusy);
          emit(8'h00, 1'b0, StMalformed);
        end
        ModeAfter: emit(8'h00, nul_en, StDone);
        default: begin
          emit(8'h00, 1'b0, (err_st >= StNoQuote && err_st <= StMalformed) ? err_st : StMalformed);
        end
      endcase
      cur_mode = ModeQuote;
      esc_val  = 8'h00;
      esc_cnt  = 2'd0;
      err_st   = StBusy;
    end else begin
      case (cur_mode)
        ModeQuote: begin
          if (c == ChQuote) begin
            cur_mode = ModeStr;
          end else begin
            cur_mode = ModeErr;
            err_st   = StNoQuote;
          end
        end
        ModeStr: plain_char(c);
        ModeBsl: begin
          cur_mode = ModeStr;
          case (c)
            ChLowA: emit(ChBel, 1'b1, StBusy);
            ChLowB: emit(ChBs, 1'b1, StBusy);
            ChLowF: emit(ChFf, 1'b1, StBusy);
            ChLowN: emit(ChLf, 1'b1, StBusy);
            ChLowR: emit(ChCr, 1'b1, StBusy);
            ChLowT: emit(ChTab, 1'b1, StBusy);
            ChLowV: emit(ChVt, 1'b1, StBusy);
            ChLowX: begin
              cur_mode = ModeHex;
              esc_val  = 8'h00;
              esc_cnt  = 2'd0;
            end
            default: begin
              if (c >= ChZero && c <= ChSeven) begin
                cur_mode = ModeOct;
                esc_val  = c - ChZero;
                esc_cnt  = 2'd1;
              end else begin
                emit(c, 1'b1, StBusy);
              end
            end
          endcase
        end
        ModeHex: begin
          h = -1;
          if (c >= ChZero && c <= ChNine) h = c - ChZero;
          else if (c >= ChLowA && c <= ChLowF) h = c - ChLowA + 10;
          else if (c >= ChUpA && c <= ChUpF) h = c - ChUpA + 10;
          if (h >= 0) begin
            esc_val = {esc_val[3:0], h[3:0]};
            esc_cnt = esc_cnt + 2'd1;
            if (esc_cnt >= 2'd2) begin
              emit(esc_val, 1'b1, StBusy);
              cur_mode = ModeStr;
            end
          end else if (esc_cnt == 2'd0) begin
            cur_mode = ModeErr;
            err_st   = StNoHex;
          end else begin
            // escape cut short: its byte, then the char on its own
            emit(esc_val, 1'b1, StBusy);
            cur_mode = ModeStr;
            plain_char(c);
          end
        end
        ModeOct: begin
          if (c >= ChZero && c <= ChSeven && esc_cnt < 2'd3) begin
            esc_val = (esc_val << 3) + (c - ChZero);
            esc_cnt = esc_cnt + 2'd1;
            if (esc_cnt >= 2'd3) begin
              emit(esc_val, 1'b1, StBusy);
              cur_mode = ModeStr;
            end
          end else begin
            emit(esc_val, 1'b1, StBusy);
            cur_mode = ModeStr;
            plain_char(c);
          end
        end
        ModeAfter: begin
          if (!(c == ChSpace || c == ChTab || c == ChLf || c == ChVt || c == ChFf ||
                c == ChCr)) begin
            cur_mode = ModeErr;
            err_st   = StMalformed;
          end
        end
        default: cur_mode = ModeErr;
      endcase
    end
    if (step_n == 0) emit(8'h00, 1'b0, StBusy);
    step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endtask

  task automatic note_mismatch(input string field, input logic [7:0] e, input logic [7:0] a);
    mismatches++;
    $display("%0t: %s mismatch, expected %h got %h", $time, field, e, a);
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word, expected none got byte %h valid %b status %0d last %b",
               $time, got.out_byte, got.byte_valid, got.status, got.last);
    end else begin
      want = decoded_q.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte) note_mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.byte_valid !== want.byte_valid) begin
        note_mismatch("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      end
      if (got.status !== want.status) note_mismatch("status", 8'(want.status), 8'(got.status));
      if (got.last !== want.last) note_mismatch("last", 8'(want.last), 8'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = ModeQuote;
      esc_val  = 8'h00;
      esc_cnt  = 2'd0;
      err_st   = StBusy;
      nul_en   = 1'b1;
      decoded_q.delete();
      pending  = 0;
    end else begin
      if (pop_i && !empty_i) compare_result(result_i);
      if (push_i && !full_i) predict_word(item_i);
      if (cfg_valid_i && cfg_ready_i) nul_en = cfg_data_i;
      pending = decoded_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top: clock, reset, operand text stimulus, receiver pacing and the verdict.
module tb_top;
  import qsed_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int          TargetWords = 1450;
  localparam int          Phases      = 6;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push, full, empty, pop;
  logic      cfg_valid, cfg_ready, cfg_data;
  in_item_t  item;
  out_item_t result;
  logic      quiet = 1'b0;
  logic      hold_req = 1'b0;
  int        fail_count, pending, checked;
  int        words_sent = 0;
  int        strings_sent = 0;
  int        good_strings = 0;
  int        cfg_writes = 0;
  int unsigned cycles = 0;
  logic [7:0] ws_chars[6]  = '{ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};
  logic [7:0] named_esc[9] = '{ChLowA, ChLowB, ChLowF, ChLowN, ChLowR, ChLowT, ChLowV,
                               ChBsl, ChQuote};

  quoted_string_escape_decoder i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .item_i     (item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  qsed_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .item_i      (item),
    .empty_i     (empty),
    .pop_i       (pop),
    .result_i    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #10 clk = ~clk;

  task automatic send_word(input logic [7:0] c, input logic eot);
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < 13) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push <= 1'b1;
    item <= '{ch: c, end_of_text: eot};
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // plain char or one escape of any kind
  task automatic send_segment();
    int         sel, nd, v;
    logic [7:0] c;
    sel = $urandom_range(9);
    if (sel < 4) begin
      c = 8'($urandom_range(255));
      while (c == ChQuote || c == ChBsl) c = 8'($urandom_range(255));
      send_word(c, 1'b0);
    end else begin
      send_word(ChBsl, 1'b0);
      if (sel == 4) begin
        send_word(named_esc[$urandom_range(8)], 1'b0);
      end else if (sel < 7) begin
        send_word(ChLowX, 1'b0);
        nd = ($urandom_range(15) == 0) ? 0 : $urandom_range(2, 1);
        repeat (nd) begin
          v = $urandom_range(15);
          if (v < 10) c = ChZero + 8'(v);
          else c = ($urandom_range(1) ? ChLowA : ChUpA) + 8'(v - 10);
          send_word(c, 1'b0);
        end
      end else if (sel < 9) begin
        repeat ($urandom_range(3, 1)) send_word(ChZero + 8'($urandom_range(7)), 1'b0);
      end else begin
        send_word(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  task automatic send_random_string();
    int v;
    if ($urandom_range(99) < 85) begin
      send_word(ChQuote, 1'b0);
      repeat ($urandom_range(10)) send_segment();
      if ($urandom_range(9) != 0) send_word(ChQuote, 1'b0);
      repeat ($urandom_range(2)) send_word(ws_chars[$urandom_range(5)], 1'b0);
      if ($urandom_range(19) == 0) send_word(8'($urandom_range(255)), 1'b0);
      send_end();
      good_strings++;
    end else begin
      // noise: stray quotes, backslashes and raw bytes
      repeat ($urandom_range(8)) begin
        v = $urandom_range(5);
        send_word((v == 0) ? ChQuote : (v == 1) ? ChBsl : 8'($urandom_range(255)), 1'b0);
      end
      send_end();
    end
  endtask

  task automatic set_append_nul(input logic v);
    @(negedge clk);
    push <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : receiver
    int held;
    held = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < 300) begin
        pop <= 1'b0;
        held++;
      end else begin
        pop <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[quoted_string_escape_decoder] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [0:Phases-1] nul_plan;
    nul_plan  = 6'b010110;
    push      = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end with no text at all
    send_end();
    // zero and 0xFF chars, escaped plain char, hex cut short, closing, vt, zero byte appended
    send_text("\"");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("\\q\\xfz\"");
    send_word(ChVt, 1'b0);
    send_end();
    // octal wraps modulo 256, then an unterminated escape
    send_text("\"\\777\\");
    send_end();
    // pending octal at end
    send_text("\"\\1");
    send_end();
    // hex with no digit, rest ignored
    send_text("\"\\x\"");
    send_end();

    for (int p = 0; p < Phases; p++) begin
      set_append_nul(nul_plan[p]);
      quiet = (p == 2);
      if (p == 3) hold_req = 1'b1;
      while (words_sent < (p + 1) * TargetWords / Phases) send_random_string();
    end

    @(negedge clk);
    push <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d words in %0d strings (%0d quoted), %0d result words checked.",
             words_sent, strings_sent, good_strings, checked);
    $display("append_nul written %0d times; long receiver hold-off and drained pauses run.",
             cfg_writes);
    if (fail_count == 0) begin
      $display("[quoted_string_escape_decoder] OK");
    end else begin
      $display("[quoted_string_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule
